// File: hdl/ppf_pkg.sv
package ppf_pkg;

    localparam int DEPTH_DEFAULT       = 1024;
    localparam int ENTRY_WIDTH_DEFAULT = 64;

    localparam int CMD_W       = 2;
    localparam int RATE_W      = 18;
    localparam int LINES_W     = 12;
    localparam int ACC_W       = 22;
    localparam int FILL_W      = 10;
    localparam int UNDERRUN_W  = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 18;

    localparam logic [RATE_W-1:0]  RATE_DEFAULT  = RATE_W'(48000);
    localparam logic [LINES_W-1:0] LINES_DEFAULT = LINES_W'(525);

    localparam int FRAMES_PER_SEC     = 60;
    localparam int SAMPLES_PER_PACKET = 4;
    localparam int SLACK_FRAMES       = 8;
    localparam int THRESH_MUL         = SAMPLES_PER_PACKET * FRAMES_PER_SEC;
    localparam int CEIL_MUL           = SLACK_FRAMES * FRAMES_PER_SEC;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_TICK = 2'd1,
        CMD_PULL = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SAMPLE_RATE = 8'd0,
        REG_LINES       = 8'd1
    } reg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic tick;
        logic pull;
    } pace_req_t;

    typedef struct packed {
        logic due;
    } pace_stat_t;

endpackage

// File: hdl/ppf_if.sv
interface ppf_req_if #(
    parameter int ENTRY_WIDTH = ppf_pkg::ENTRY_WIDTH_DEFAULT
);
    import ppf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [ENTRY_WIDTH-1:0] entry_data;

    modport source (output valid, output command, output entry_data, input ready);
    modport sink   (input valid, input command, input entry_data, output ready);
endinterface

interface ppf_rsp_if #(
    parameter int ENTRY_WIDTH = ppf_pkg::ENTRY_WIDTH_DEFAULT
);
    import ppf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   push_accepted;
    logic                   packet_valid;
    logic                   silence_substitute;
    logic [ENTRY_WIDTH-1:0] packet_data;
    logic [FILL_W-1:0]      fill_level;
    logic [UNDERRUN_W-1:0]  underrun_total;

    modport source (
        output valid, output push_accepted, output packet_valid,
        output silence_substitute, output packet_data, output fill_level,
        output underrun_total, input ready
    );
    modport sink (
        input valid, input push_accepted, input packet_valid,
        input silence_substitute, input packet_data, input fill_level,
        input underrun_total, output ready
    );
endinterface

interface ppf_cfg_if;
    import ppf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/ppf_ram.sv
module ppf_ram #(
    parameter int WIDTH = ppf_pkg::ENTRY_WIDTH_DEFAULT,
    parameter int DEPTH = ppf_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hdl/ppf_pacer.sv
module ppf_pacer (
    input  logic               clk,
    input  logic               rst_n,
    ppf_cfg_if.sink            cfg,
    input  ppf_pkg::pace_req_t pace_req,
    output ppf_pkg::pace_stat_t pace_stat
);
    import ppf_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [LINES_W-1:0] lines_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]   threshold;
    logic [ACC_W:0]     ceiling;
    logic [ACC_W:0]     sum;
    logic               cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    assign threshold = ACC_W'(ACC_W'(lines_reg) * ACC_W'(THRESH_MUL));
    assign ceiling   = (ACC_W + 1)'((ACC_W + 1)'(lines_reg) * (ACC_W + 1)'(CEIL_MUL));
    assign sum       = {1'b0, acc_reg} + (ACC_W + 1)'(rate_reg);

    assign pace_stat.due = (acc_reg >= threshold);

    always_comb
    begin
        acc_next = acc_reg;
        if (pace_req.tick)
        begin
            acc_next = (sum > ceiling) ? ceiling[ACC_W-1:0] : sum[ACC_W-1:0];
        end
        else if (pace_req.pull && pace_stat.due)
        begin
            acc_next = acc_reg - threshold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_DEFAULT;
            lines_reg <= LINES_DEFAULT;
            acc_reg   <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cfg_write && cfg.index == REG_SAMPLE_RATE)
            begin
                rate_reg <= (cfg.data == '0) ? RATE_DEFAULT : RATE_W'(cfg.data);
            end
            if (cfg_write && cfg.index == REG_LINES)
            begin
                lines_reg <= LINES_W'(cfg.data);
            end
        end
    end
endmodule

// File: hdl/paced_packet_fifo.sv
// Ring FIFO of packet entries whose pulls are paced by a sample-rate accumulator
// fed by scanline ticks. Words are taken one at a time: a push, a tick, a nop,
// a pull that is not due or a due pull on an empty ring registers its result at
// acceptance, and the next word is taken in the same cycle that result is taken,
// so these sustain one word per cycle while rsp.ready stays high. A due pull
// that removes an entry reads the entry RAM first and registers the entry in
// the load state, taking no new word until then. At most DEPTH-1 entries are
// held. Configuration writes should only be issued while the block is idle.
module paced_packet_fifo #(
    parameter int DEPTH       = ppf_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = ppf_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    ppf_req_if.sink  req,
    ppf_rsp_if.source rsp,
    ppf_cfg_if.sink  cfg
);
    import ppf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FW    = (PTR_W + 1 > FILL_W) ? PTR_W + 1 : FILL_W;

    state_t state_reg;
    state_t state_next;

    logic [PTR_W-1:0]       wr_reg, wr_next, wr_inc;
    logic [PTR_W-1:0]       rd_reg, rd_next, rd_inc;
    logic [UNDERRUN_W-1:0]  underrun_reg, underrun_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   accepted_reg, accepted_next;
    logic                   pkt_valid_reg, pkt_valid_next;
    logic                   silence_reg, silence_next;
    logic [ENTRY_WIDTH-1:0] data_reg, data_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FW-1:0]          fill_wide;

    logic                   accept;
    logic                   full;
    logic                   empty;
    cmd_t                   cmd;
    logic                   ram_we;
    logic                   ram_re;
    logic [ENTRY_WIDTH-1:0] ram_rdata;
    pace_req_t              pace_req;
    pace_stat_t             pace_stat;

    assign cmd    = cmd_t'(req.command);
    assign wr_inc = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign rd_inc = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
    assign full   = (wr_inc == rd_reg);
    assign empty  = (wr_reg == rd_reg);

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign pace_req.tick = accept && (cmd == CMD_TICK);
    assign pace_req.pull = accept && (cmd == CMD_PULL);

    ppf_pacer u_pacer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pace_req  (pace_req),
        .pace_stat (pace_stat)
    );

    ppf_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_reg),
        .wdata (req.entry_data),
        .re    (ram_re),
        .raddr (rd_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        underrun_next  = underrun_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        accepted_next  = accepted_reg;
        pkt_valid_next = pkt_valid_reg;
        silence_next   = silence_reg;
        data_next      = data_reg;
        fill_next      = fill_reg;
        fill_wide      = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    accepted_next  = 1'b0;
                    pkt_valid_next = 1'b0;
                    silence_next   = 1'b0;
                    data_next      = '0;
                    out_valid_next = 1'b1;
                    unique case (cmd)
                        CMD_PUSH:
                        begin
                            if (!full)
                            begin
                                ram_we        = 1'b1;
                                wr_next       = wr_inc;
                                accepted_next = 1'b1;
                            end
                        end
                        CMD_PULL:
                        begin
                            if (pace_stat.due)
                            begin
                                pkt_valid_next = 1'b1;
                                if (!empty)
                                begin
                                    ram_re         = 1'b1;
                                    rd_next        = rd_inc;
                                    out_valid_next = 1'b0;
                                    state_next     = ST_LOAD;
                                end
                                else
                                begin
                                    underrun_next = underrun_reg + 1'b1;
                                    silence_next  = 1'b1;
                                end
                            end
                        end
                        CMD_TICK, CMD_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                    fill_wide = FW'(wr_next) - FW'(rd_next)
                                + ((wr_next < rd_next) ? FW'(DEPTH) : FW'(0));
                    fill_next = fill_wide[FILL_W-1:0];
                end
            end
            ST_LOAD:
            begin
                data_next      = ram_rdata;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg        <= '0;
            rd_reg        <= '0;
            underrun_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            underrun_reg  <= underrun_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg  <= accepted_next;
        pkt_valid_reg <= pkt_valid_next;
        silence_reg   <= silence_next;
        data_reg      <= data_next;
        fill_reg      <= fill_next;
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.push_accepted      = accepted_reg;
    assign rsp.packet_valid       = pkt_valid_reg;
    assign rsp.silence_substitute = silence_reg;
    assign rsp.packet_data        = data_reg;
    assign rsp.fill_level         = fill_reg;
    assign rsp.underrun_total     = underrun_reg;
endmodule
